FILE: sv/upc_pkg.sv
// ----------------------------------------------------------------------------
// upc_pkg
// Shared types and constants for the URL path segment checker.
// ----------------------------------------------------------------------------
package upc_pkg;

  localparam int unsigned MAX_SEGMENTS_DEFAULT = 16;

  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_QUERY   = 8'h3F;
  localparam logic [7:0] CHAR_HASH    = 8'h23;
  localparam logic [7:0] CHAR_PERCENT = 8'h25;

  localparam int unsigned NUM_SYMS = 15;
  localparam logic [7:0] SYM_CHARS [NUM_SYMS] = '{
    8'h2D, 8'h2E, 8'h5F, 8'h7E, 8'h21, 8'h24, 8'h26, 8'h27,
    8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h3B, 8'h3D
  };

  typedef enum logic [1:0] {
    REGION_PATH  = 2'd0,
    REGION_QUERY = 2'd1,
    REGION_FRAG  = 2'd2
  } region_t;

  typedef struct packed {
    logic is_slash;
    logic is_query;
    logic is_hash;
    logic is_percent;
    logic is_hex;
    logic is_plain;
  } char_class_t;

  typedef struct packed {
    logic [1:0] region;
    logic       is_segment_byte;
    logic [3:0] segment_index;
    logic       segment_closed;
    logic       closed_segment_ok;
    logic       route_ok;
    logic [4:0] segment_total;
    logic       segment_overflow;
    logic       route_done;
  } result_t;

endpackage

FILE: sv/upc_in_if.sv
// ----------------------------------------------------------------------------
// upc_in_if
// Input channel: one request-target byte per transaction.
// ----------------------------------------------------------------------------
interface upc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_byte;

  modport source (output valid, output byte_in, output last_byte, input ready);
  modport sink (input valid, input byte_in, input last_byte, output ready);
endinterface

FILE: sv/upc_out_if.sv
// ----------------------------------------------------------------------------
// upc_out_if
// Output channel: one checker result per transaction.
// ----------------------------------------------------------------------------
interface upc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] region;
  logic       is_segment_byte;
  logic [3:0] segment_index;
  logic       segment_closed;
  logic       closed_segment_ok;
  logic       route_ok;
  logic [4:0] segment_total;
  logic       segment_overflow;
  logic       route_done;

  modport source (
    output valid, output region, output is_segment_byte, output segment_index,
    output segment_closed, output closed_segment_ok, output route_ok,
    output segment_total, output segment_overflow, output route_done,
    input ready
  );
  modport sink (
    input valid, input region, input is_segment_byte, input segment_index,
    input segment_closed, input closed_segment_ok, input route_ok,
    input segment_total, input segment_overflow, input route_done,
    output ready
  );
endinterface

FILE: sv/upc_char_class.sv
// ----------------------------------------------------------------------------
// upc_char_class
// Classifies one byte: delimiters, percent, hex digit, plain segment char.
// ----------------------------------------------------------------------------
module upc_char_class (
  input  logic [7:0]           ch,
  output upc_pkg::char_class_t cls
);

  logic sym_hit;
  logic is_digit;
  logic is_upper;
  logic is_lower;

  always_comb begin
    sym_hit = 1'b0;
    for (int k = 0; k < upc_pkg::NUM_SYMS; k++) begin
      if (ch == upc_pkg::SYM_CHARS[k]) begin
        sym_hit = 1'b1;
      end
    end
  end

  assign is_digit = (ch >= 8'h30) && (ch <= 8'h39);
  assign is_upper = (ch >= 8'h41) && (ch <= 8'h5A);
  assign is_lower = (ch >= 8'h61) && (ch <= 8'h7A);

  assign cls.is_slash   = (ch == upc_pkg::CHAR_SLASH);
  assign cls.is_query   = (ch == upc_pkg::CHAR_QUERY);
  assign cls.is_hash    = (ch == upc_pkg::CHAR_HASH);
  assign cls.is_percent = (ch == upc_pkg::CHAR_PERCENT);
  assign cls.is_hex     = is_digit || ((ch >= 8'h41) && (ch <= 8'h46)) ||
                          ((ch >= 8'h61) && (ch <= 8'h66));
  assign cls.is_plain   = is_digit || is_upper || is_lower || sym_hit;

endmodule

FILE: sv/upc_seg_tracker.sv
// ----------------------------------------------------------------------------
// upc_seg_tracker
// Per-target state: region, percent escapes, segment and route validity,
// saturating segment count. Produces the result of each accepted byte.
// ----------------------------------------------------------------------------
module upc_seg_tracker #(
  parameter int unsigned MAX_SEGMENTS = upc_pkg::MAX_SEGMENTS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic [7:0]           byte_in,
  input  logic                 last_byte,
  output upc_pkg::result_t     result
);

  localparam int unsigned CntW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned ExtW = (CntW > 5) ? CntW : 5;
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_SEGMENTS);

  upc_pkg::char_class_t cls;

  upc_pkg::region_t cur_region, cur_region_next;
  logic [1:0]       hex_digits_owed, hex_digits_owed_next;
  logic             segment_nonempty, segment_nonempty_next;
  logic             segment_valid, segment_valid_next;
  logic             route_valid, route_valid_next;
  logic [CntW-1:0]  segment_count, segment_count_next;
  logic             count_overflow, count_overflow_next;

  logic            in_path;
  logic            delim;
  logic            seg_byte;
  logic            bad_char;
  logic [1:0]      owed_after;
  logic            nonempty_after;
  logic            closing;
  logic            cok;
  logic [ExtW-1:0] cnt_now_ext;
  logic [ExtW-1:0] cnt_next_ext;

  upc_char_class u_class (
    .ch  (byte_in),
    .cls (cls)
  );

  assign in_path  = (cur_region == upc_pkg::REGION_PATH);
  assign delim    = cls.is_slash || cls.is_query || cls.is_hash;
  assign seg_byte = in_path && !delim;

  always_comb begin
    bad_char   = 1'b0;
    owed_after = hex_digits_owed;
    if (seg_byte) begin
      if (hex_digits_owed != 2'd0) begin
        bad_char   = !cls.is_hex;
        owed_after = hex_digits_owed - 2'd1;
      end
      if (cls.is_percent) begin
        owed_after = 2'd2;
      end else if (!cls.is_plain) begin
        bad_char = 1'b1;
      end
    end
  end

  assign nonempty_after = segment_nonempty || seg_byte;
  assign closing        = in_path && (delim || last_byte) && nonempty_after;
  assign cok            = closing && segment_valid && !bad_char && (owed_after == 2'd0);

  always_comb begin
    cur_region_next       = cur_region;
    hex_digits_owed_next  = owed_after;
    segment_nonempty_next = nonempty_after;
    segment_valid_next    = segment_valid && !bad_char;
    route_valid_next      = route_valid;
    segment_count_next    = segment_count;
    count_overflow_next   = count_overflow;

    case (cur_region)
      upc_pkg::REGION_PATH: begin
        if (cls.is_query) begin
          cur_region_next = upc_pkg::REGION_QUERY;
        end else if (cls.is_hash) begin
          cur_region_next = upc_pkg::REGION_FRAG;
        end
      end
      upc_pkg::REGION_QUERY: begin
        if (cls.is_hash) begin
          cur_region_next = upc_pkg::REGION_FRAG;
        end
      end
      default: begin
        cur_region_next = upc_pkg::REGION_FRAG;
      end
    endcase

    if (closing) begin
      if (!cok) begin
        route_valid_next = 1'b0;
      end else if (route_valid) begin
        if (segment_count < CntMax) begin
          segment_count_next = segment_count + 1'b1;
        end else begin
          count_overflow_next = 1'b1;
        end
      end
      segment_nonempty_next = 1'b0;
      segment_valid_next    = 1'b1;
      hex_digits_owed_next  = 2'd0;
    end
  end

  assign cnt_now_ext  = ExtW'(segment_count);
  assign cnt_next_ext = ExtW'(segment_count_next);

  always_comb begin
    result.region            = cur_region_next;
    result.is_segment_byte   = seg_byte;
    result.segment_index     = (cnt_now_ext >= ExtW'(15)) ? 4'd15 : cnt_now_ext[3:0];
    result.segment_closed    = closing;
    result.closed_segment_ok = cok;
    result.route_ok          = route_valid_next;
    result.segment_total     = cnt_next_ext[4:0];
    result.segment_overflow  = count_overflow_next;
    result.route_done        = last_byte;
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && last_byte)) begin
      cur_region       <= upc_pkg::REGION_PATH;
      hex_digits_owed  <= 2'd0;
      segment_nonempty <= 1'b0;
      segment_valid    <= 1'b1;
      route_valid      <= 1'b1;
      segment_count    <= '0;
      count_overflow   <= 1'b0;
    end else if (advance) begin
      cur_region       <= cur_region_next;
      hex_digits_owed  <= hex_digits_owed_next;
      segment_nonempty <= segment_nonempty_next;
      segment_valid    <= segment_valid_next;
      route_valid      <= route_valid_next;
      segment_count    <= segment_count_next;
      count_overflow   <= count_overflow_next;
    end
  end

endmodule

FILE: sv/url_path_segment_checker.sv
// ----------------------------------------------------------------------------
// url_path_segment_checker
// Checks the path segments of a request target streamed one byte at a time.
//
// req carries one target byte per transaction, with last_byte marking the
// final byte of a target. rsp returns exactly one result per byte, in order:
// the byte's region, segment membership and index, whether it closed a
// segment and that segment's validity, and running route status and count.
// On the result with route_done set, the other fields are the final values
// for the target, and the tracker then returns to its reset state.
// rsp.valid rises in the cycle after acceptance; throughput is one byte per
// cycle while rsp is not stalled, set by the single result register behind
// the per-byte state update. If rsp is stalled the result register holds and
// req.ready drops until it is taken. Synchronous reset clears the tracker
// state and empties the result register.
// ----------------------------------------------------------------------------
module url_path_segment_checker #(
  parameter int unsigned MAX_SEGMENTS = upc_pkg::MAX_SEGMENTS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  upc_in_if.sink     req,
  upc_out_if.source  rsp
);

  logic             accept;
  logic             out_valid;
  upc_pkg::result_t result;
  upc_pkg::result_t out_data;

  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  upc_seg_tracker #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_tracker (
    .clk       (clk),
    .rst       (rst),
    .advance   (accept),
    .byte_in   (req.byte_in),
    .last_byte (req.last_byte),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (accept) begin
      out_data <= result;
    end
  end

  assign rsp.valid             = out_valid;
  assign rsp.region            = out_data.region;
  assign rsp.is_segment_byte   = out_data.is_segment_byte;
  assign rsp.segment_index     = out_data.segment_index;
  assign rsp.segment_closed    = out_data.segment_closed;
  assign rsp.closed_segment_ok = out_data.closed_segment_ok;
  assign rsp.route_ok          = out_data.route_ok;
  assign rsp.segment_total     = out_data.segment_total;
  assign rsp.segment_overflow  = out_data.segment_overflow;
  assign rsp.route_done        = out_data.route_done;

endmodule
